// File: rtl/fbsca_pkg.sv
package fbsca_pkg;

  // Field and register widths
  localparam int CFG_W   = 12;
  localparam int CHAN_W  = 8;
  localparam int SUM_W   = 32;
  localparam int LED_W   = 14;
  localparam int SEGI_W  = 6;
  localparam int CIDX_W  = 3;
  localparam int COUNT_W = 11;

  localparam logic [CFG_W-1:0] MAX_FRAME_LINES = 12'd2048;

  // floor(h / 3) == (h * 2731) >> 13 for every h up to 2048
  localparam logic [CFG_W-1:0] THIRD_MULT  = 12'd2731;
  localparam int               THIRD_SHIFT = 13;
  localparam int               THIRD_W     = 2 * CFG_W - THIRD_SHIFT;

  // Width of the elaboration-time reciprocal of the segment count
  localparam int RECIP_W = 14;

  // Divider: 9 quotient bits, top bit set means the mean saturates at 255
  localparam int QUO_W      = 9;
  localparam int MEAN_STEPS = 9;
  localparam int STEP_W     = 4;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RST = 12'd480;
  localparam logic [CHAN_W-1:0] RED_OFFSET_RST   = 8'd10;
  localparam logic [CHAN_W-1:0] GREEN_OFFSET_RST = 8'd10;
  localparam logic [CHAN_W-1:0] BLUE_OFFSET_RST  = 8'd20;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_RED_OFFSET   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_GREEN_OFFSET = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_BLUE_OFFSET  = 3'd4;

endpackage

// File: rtl/frame_band_segment_color_average.sv
// Per-segment color averager for a raster RGB stream. Pixels enter one per transaction
// (start while busy is low), and busy stays high while the block works on a pixel. A
// pixel inside the middle-third band holds the block longer than one outside it, as the
// shared restoring divider first maps its column to its segment. On the last pixel of a
// frame the same divider computes the three channel means of every segment one after
// another, 9 steps per channel, while busy stays high. Results leave one per segment, left
// to right, each marked by out_valid for a single cycle; there is no backpressure, the
// receiver must take every result as it comes. Configuration writes apply at once and
// must only be made while busy is low.
module frame_band_segment_color_average
  import fbsca_pkg::*;
#(
  parameter int SEGMENT_COUNT    = 16,
  parameter int LEDS_PER_SEGMENT = 16,
  parameter int MAX_LINE_PIXELS  = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic [CHAN_W-1:0] in_pixel_red,
  input  logic [CHAN_W-1:0] in_pixel_green,
  input  logic [CHAN_W-1:0] in_pixel_blue,
  input  logic              in_frame_start,
  output logic              out_valid,
  output logic [SEGI_W-1:0] out_segment_index,
  output logic [CHAN_W-1:0] out_red_level,
  output logic [CHAN_W-1:0] out_green_level,
  output logic [CHAN_W-1:0] out_blue_level,
  output logic [23:0]       out_packed_color,
  output logic [LED_W-1:0]  out_led_start,
  output logic              out_last_segment
);

  localparam int IDX_W       = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
  localparam int COL_STEPS   = IDX_W + 1;
  localparam int RECIP_SHIFT = CFG_W + $clog2(SEGMENT_COUNT);
  localparam int RECIP       = ((1 << RECIP_SHIFT) + SEGMENT_COUNT - 1) / SEGMENT_COUNT;
  localparam int SWP_W       = CFG_W + RECIP_W;
  localparam int CNT_W       = CFG_W + THIRD_W;

  localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(SEGMENT_COUNT - 1);
  localparam logic [CFG_W-1:0]   MAX_W    = CFG_W'(MAX_LINE_PIXELS);
  localparam logic [LED_W-1:0]   LED_STEP = LED_W'(LEDS_PER_SEGMENT);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SETUP, S_CDIV, S_CRD, S_CACC, S_ADV,
    S_ERD, S_ELOAD, S_EDIV, S_EOUT
  } state_t;

  typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} chan_t;

  state_t              state_r;
  chan_t               ch_r;

  logic [CFG_W-1:0]    frame_width_r, frame_height_r;
  logic [CHAN_W-1:0]   red_offset_r, green_offset_r, blue_offset_r;

  logic [CHAN_W-1:0]   pix_red_r, pix_green_r, pix_blue_r;
  logic [COUNT_W-1:0]  col_r, row_r;
  logic [CFG_W-1:0]    seg_w_r;
  logic [THIRD_W-1:0]  third_r;
  logic [CNT_W-1:0]    count_r;
  logic [IDX_W-1:0]    seg_r, k_r;
  logic [LED_W-1:0]    led_r;
  logic [CHAN_W-1:0]   mean_red_r, mean_green_r, mean_blue_r;
  logic [SEGMENT_COUNT-1:0] valid_r;

  logic [SUM_W-1:0]    rem_r, dsh_r;
  logic [QUO_W-1:0]    quo_r;
  logic [STEP_W-1:0]   step_r;

  logic [3*SUM_W-1:0]  sum_mem [SEGMENT_COUNT];
  logic [3*SUM_W-1:0]  rd_word_r;
  logic                rd_valid_r;

  logic                out_valid_r, out_last_r;
  logic [SEGI_W-1:0]   out_seg_r;
  logic [CHAN_W-1:0]   out_red_r, out_green_r, out_blue_r;
  logic [LED_W-1:0]    out_led_r;

  logic [CFG_W-1:0]    w_eff, h_eff;
  logic [SWP_W-1:0]    sw_prod;
  logic [2*CFG_W-1:0]  th_prod;
  logic [CNT_W-1:0]    cnt_prod;
  logic                in_band;
  logic                div_ge;
  logic [SUM_W-1:0]    rem_nxt;
  logic [QUO_W-1:0]    quo_nxt;
  logic                col_hit;
  logic [CHAN_W-1:0]   mean_nxt;
  logic [SUM_W-1:0]    rd_red, rd_green, rd_blue, chan_sum;
  logic [IDX_W-1:0]    mem_addr;
  logic                mem_we;
  logic [3*SUM_W-1:0]  mem_wdata;
  logic                end_col, end_row;
  logic [CHAN_W-1:0]   lvl_red, lvl_green, lvl_blue;

  function automatic logic [CHAN_W-1:0] level_of(input logic [CHAN_W-1:0] mean,
                                                 input logic [CHAN_W-1:0] offset);
    level_of = (mean > offset) ? (mean - offset) : '0;
  endfunction

  // Effective frame size, clamped to 1..max
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = CFG_W'(1);
    end else if (frame_width_r > MAX_W) begin
      w_eff = MAX_W;
    end else begin
      w_eff = frame_width_r;
    end
    if (frame_height_r == '0) begin
      h_eff = CFG_W'(1);
    end else if (frame_height_r > MAX_FRAME_LINES) begin
      h_eff = MAX_FRAME_LINES;
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign sw_prod  = w_eff * RECIP_C;
  assign th_prod  = h_eff * THIRD_MULT;
  assign cnt_prod = seg_w_r * third_r;

  assign in_band = (seg_w_r != '0) && ({1'b0, row_r} >= {1'b0, third_r}) &&
                   ({1'b0, row_r} < ({1'b0, third_r} << 1));

  assign end_col = {1'b0, col_r} >= (w_eff - CFG_W'(1));
  assign end_row = {1'b0, row_r} >= (h_eff - CFG_W'(1));

  // Shared restoring divider step
  assign div_ge  = rem_r >= dsh_r;
  assign rem_nxt = div_ge ? (rem_r - dsh_r) : rem_r;
  assign quo_nxt = {quo_r[QUO_W-2:0], div_ge};

  // Column quotient fits in IDX_W bits and names an existing segment
  assign col_hit = !quo_nxt[IDX_W] && (quo_nxt[IDX_W-1:0] <= LAST_IDX);

  always_comb begin
    if (count_r == '0) begin
      mean_nxt = '0;
    end else if (quo_nxt[QUO_W-1]) begin
      mean_nxt = '1;
    end else begin
      mean_nxt = quo_nxt[CHAN_W-1:0];
    end
  end

  // Entries not yet written since the last clear read as zero
  assign rd_red   = rd_valid_r ? rd_word_r[3*SUM_W-1:2*SUM_W] : '0;
  assign rd_green = rd_valid_r ? rd_word_r[2*SUM_W-1:SUM_W]   : '0;
  assign rd_blue  = rd_valid_r ? rd_word_r[SUM_W-1:0]         : '0;

  always_comb begin
    case (ch_r)
      CH_RED:   chan_sum = rd_red;
      CH_GREEN: chan_sum = rd_green;
      CH_BLUE:  chan_sum = rd_blue;
      default:  chan_sum = '0;
    endcase
  end

  assign mem_addr  = (state_r == S_CRD || state_r == S_CACC) ? seg_r : k_r;
  assign mem_we    = (state_r == S_CACC);
  assign mem_wdata = {rd_red + SUM_W'(pix_red_r), rd_green + SUM_W'(pix_green_r),
                      rd_blue + SUM_W'(pix_blue_r)};

  assign lvl_red   = level_of(mean_red_r, red_offset_r);
  assign lvl_green = level_of(mean_green_r, green_offset_r);
  assign lvl_blue  = level_of(mean_blue_r, blue_offset_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_addr] <= mem_wdata;
    end
    rd_word_r  <= sum_mem[mem_addr];
    rd_valid_r <= valid_r[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      red_offset_r   <= RED_OFFSET_RST;
      green_offset_r <= GREEN_OFFSET_RST;
      blue_offset_r  <= BLUE_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        CFG_RED_OFFSET:   red_offset_r   <= cfg_wdata[CHAN_W-1:0];
        CFG_GREEN_OFFSET: green_offset_r <= cfg_wdata[CHAN_W-1:0];
        CFG_BLUE_OFFSET:  blue_offset_r  <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= CH_RED;
      col_r       <= '0;
      row_r       <= '0;
      valid_r     <= '0;
      k_r         <= '0;
      led_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            pix_red_r   <= in_pixel_red;
            pix_green_r <= in_pixel_green;
            pix_blue_r  <= in_pixel_blue;
            if (in_frame_start) begin
              col_r   <= '0;
              row_r   <= '0;
              valid_r <= '0;
            end
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          seg_w_r <= CFG_W'(sw_prod >> RECIP_SHIFT);
          third_r <= th_prod[2*CFG_W-1:THIRD_SHIFT];
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          if (in_band) begin
            rem_r   <= SUM_W'(col_r);
            dsh_r   <= SUM_W'(seg_w_r) << IDX_W;
            quo_r   <= '0;
            step_r  <= STEP_W'(COL_STEPS - 1);
            state_r <= S_CDIV;
          end else begin
            state_r <= S_ADV;
          end
        end
        S_CDIV: begin
          rem_r <= rem_nxt;
          dsh_r <= dsh_r >> 1;
          quo_r <= quo_nxt;
          if (step_r == '0) begin
            seg_r   <= quo_nxt[IDX_W-1:0];
            state_r <= col_hit ? S_CRD : S_ADV;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        S_CRD: begin
          state_r <= S_CACC;
        end
        S_CACC: begin
          valid_r[seg_r] <= 1'b1;
          state_r        <= S_ADV;
        end
        S_ADV: begin
          if (!end_col) begin
            col_r   <= col_r + COUNT_W'(1);
            state_r <= S_IDLE;
          end else begin
            col_r <= '0;
            if (!end_row) begin
              row_r   <= row_r + COUNT_W'(1);
              state_r <= S_IDLE;
            end else begin
              count_r <= cnt_prod;
              k_r     <= '0;
              led_r   <= '0;
              ch_r    <= CH_RED;
              state_r <= S_ERD;
            end
          end
        end
        S_ERD: begin
          state_r <= S_ELOAD;
        end
        S_ELOAD: begin
          rem_r   <= chan_sum;
          dsh_r   <= SUM_W'(count_r) << CHAN_W;
          quo_r   <= '0;
          step_r  <= STEP_W'(MEAN_STEPS - 1);
          state_r <= S_EDIV;
        end
        S_EDIV: begin
          rem_r <= rem_nxt;
          dsh_r <= dsh_r >> 1;
          quo_r <= quo_nxt;
          if (step_r == '0) begin
            case (ch_r)
              CH_RED: begin
                mean_red_r <= mean_nxt;
                ch_r       <= CH_GREEN;
                state_r    <= S_ELOAD;
              end
              CH_GREEN: begin
                mean_green_r <= mean_nxt;
                ch_r         <= CH_BLUE;
                state_r      <= S_ELOAD;
              end
              default: begin
                mean_blue_r <= mean_nxt;
                state_r     <= S_EOUT;
              end
            endcase
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        S_EOUT: begin
          out_valid_r <= 1'b1;
          out_seg_r   <= SEGI_W'(k_r);
          out_red_r   <= lvl_red;
          out_green_r <= lvl_green;
          out_blue_r  <= lvl_blue;
          out_led_r   <= led_r;
          out_last_r  <= (k_r == LAST_IDX);
          if (k_r == LAST_IDX) begin
            valid_r <= '0;
            row_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + IDX_W'(1);
            led_r   <= led_r + LED_STEP;
            ch_r    <= CH_RED;
            state_r <= S_ERD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_segment_index = out_seg_r;
  assign out_red_level     = out_red_r;
  assign out_green_level   = out_green_r;
  assign out_blue_level    = out_blue_r;
  assign out_packed_color  = {out_red_r, out_green_r, out_blue_r};
  assign out_led_start     = out_led_r;
  assign out_last_segment  = out_last_r;

endmodule

// File: rtl/fbsca_checker.sv
module fbsca_checker #(
  parameter int SEGMENT_COUNT = 16
) (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [5:0] out_segment_index,
  input logic       out_last_segment
);

  // An accepted transaction raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // Results are spaced by the divider, never in adjacent cycles
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in adjacent cycles");

  // Only the final segment of a frame may appear with the block idle
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_last_segment)
    else $error("non-final result while idle");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_segment |-> out_segment_index == 6'(SEGMENT_COUNT - 1))
    else $error("last segment flag on wrong segment");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not quiet after reset");

endmodule

bind frame_band_segment_color_average fbsca_checker #(
  .SEGMENT_COUNT(SEGMENT_COUNT)
) u_fbsca_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_segment_index(out_segment_index),
  .out_last_segment (out_last_segment)
);

// File: bench/frame_band_segment_color_average_test.sv
`timescale 1ns / 1ps

module frame_band_segment_color_average_test;
  import fbsca_pkg::*;

  localparam int SEGMENTS     = 16;
  localparam int LEDS_PER_SEG = 16;
  localparam int MAX_LINE     = 2048;
  localparam int MAX_LINES    = 2048;
  localparam int RANDOM_ITEMS = 170;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct packed {
    logic [SEGI_W-1:0] segment_index;
    logic [CHAN_W-1:0] red_level;
    logic [CHAN_W-1:0] green_level;
    logic [CHAN_W-1:0] blue_level;
    logic [23:0]       packed_color;
    logic [LED_W-1:0]  led_start;
    logic              last_segment;
  } segment_result_t;

  class frame_color_scoreboard;
    logic [CFG_W-1:0]  width_reg, height_reg;
    logic [CHAN_W-1:0] red_off, green_off, blue_off;
    int unsigned       col, row;
    logic [SUM_W-1:0]  red_acc [SEGMENTS];
    logic [SUM_W-1:0]  green_acc [SEGMENTS];
    logic [SUM_W-1:0]  blue_acc [SEGMENTS];
    segment_result_t   awaited[$];
    int unsigned       errors;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      red_off    = RED_OFFSET_RST;
      green_off  = GREEN_OFFSET_RST;
      blue_off   = BLUE_OFFSET_RST;
      col        = 0;
      row        = 0;
      errors     = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      for (int k = 0; k < SEGMENTS; k++) begin
        red_acc[k]   = '0;
        green_acc[k] = '0;
        blue_acc[k]  = '0;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg  = data;
        CFG_FRAME_HEIGHT: height_reg = data;
        CFG_RED_OFFSET:   red_off    = data[CHAN_W-1:0];
        CFG_GREEN_OFFSET: green_off  = data[CHAN_W-1:0];
        CFG_BLUE_OFFSET:  blue_off   = data[CHAN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CHAN_W-1:0] channel_level(input logic [SUM_W-1:0] sum,
                                              input int unsigned cnt,
                                              input logic [CHAN_W-1:0] off);
      int unsigned mean;
      if (cnt == 0) return '0;
      mean = sum / cnt;
      if (mean > 255) mean = 255;
      return (mean > 32'(off)) ? CHAN_W'(mean - 32'(off)) : '0;
    endfunction

    function void note_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic fs);
      int unsigned     w, h, seg_w, third, seg, cnt;
      segment_result_t res;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_LINE) ? MAX_LINE : 32'(width_reg);
      h = (height_reg == 0) ? 1 : (height_reg > MAX_LINES) ? MAX_LINES : 32'(height_reg);
      seg_w = w / SEGMENTS;
      third = h / 3;
      if (fs) begin
        col = 0;
        row = 0;
        clear_sums();
      end
      if (seg_w != 0 && row >= third && row < 2 * third) begin
        seg = col / seg_w;
        if (seg < SEGMENTS) begin
          red_acc[seg]   += SUM_W'(r);
          green_acc[seg] += SUM_W'(g);
          blue_acc[seg]  += SUM_W'(b);
        end
      end
      // counters at or past the limit (after a resize) count as the line/frame end
      if (col < w - 1) begin
        col = (col + 1) & 'h7FF;
        return;
      end
      col = 0;
      if (row < h - 1) begin
        row = (row + 1) & 'h7FF;
        return;
      end
      cnt = seg_w * third;
      for (int k = 0; k < SEGMENTS; k++) begin
        res.segment_index = SEGI_W'(k);
        res.red_level     = channel_level(red_acc[k], cnt, red_off);
        res.green_level   = channel_level(green_acc[k], cnt, green_off);
        res.blue_level    = channel_level(blue_acc[k], cnt, blue_off);
        res.packed_color  = {res.red_level, res.green_level, res.blue_level};
        res.led_start     = LED_W'(k * LEDS_PER_SEG);
        res.last_segment  = (k == SEGMENTS - 1);
        awaited.insert(awaited.size(), res);
      end
      row = 0;
      clear_sums();
    endfunction

    function void compare_field(input string name, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input segment_result_t got);
      segment_result_t want;
      if (awaited.size() == 0) begin
        $error("segment result with nothing pending: segment_index %0d", got.segment_index);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("segment_index", want.segment_index, got.segment_index);
      compare_field("red_level", want.red_level, got.red_level);
      compare_field("green_level", want.green_level, got.green_level);
      compare_field("blue_level", want.blue_level, got.blue_level);
      compare_field("packed_color", want.packed_color, got.packed_color);
      compare_field("led_start", want.led_start, got.led_start);
      compare_field("last_segment", want.last_segment, got.last_segment);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              start;
  logic              busy;
  logic [CHAN_W-1:0] in_pixel_red;
  logic [CHAN_W-1:0] in_pixel_green;
  logic [CHAN_W-1:0] in_pixel_blue;
  logic              in_frame_start;
  logic              out_valid;
  logic [SEGI_W-1:0] out_segment_index;
  logic [CHAN_W-1:0] out_red_level;
  logic [CHAN_W-1:0] out_green_level;
  logic [CHAN_W-1:0] out_blue_level;
  logic [23:0]       out_packed_color;
  logic [LED_W-1:0]  out_led_start;
  logic              out_last_segment;

  frame_color_scoreboard sb;
  segment_result_t       seen;
  int unsigned           cycle_count = 0;
  int unsigned           pixels_sent = 0;
  bit                    sender_gaps = 1'b0;

  frame_band_segment_color_average u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_pixel_red     (in_pixel_red),
    .in_pixel_green   (in_pixel_green),
    .in_pixel_blue    (in_pixel_blue),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_segment_index(out_segment_index),
    .out_red_level    (out_red_level),
    .out_green_level  (out_green_level),
    .out_blue_level   (out_blue_level),
    .out_packed_color (out_packed_color),
    .out_led_start    (out_led_start),
    .out_last_segment (out_last_segment)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // results cannot be held off: take every strobe as it comes
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen.segment_index = out_segment_index;
      seen.red_level     = out_red_level;
      seen.green_level   = out_green_level;
      seen.blue_level    = out_blue_level;
      seen.packed_color  = out_packed_color;
      seen.led_start     = out_led_start;
      seen.last_segment  = out_last_segment;
      sb.check_result(seen);
    end
  end

  // called at a falling edge; returns at a falling edge with start still high
  task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input logic fs);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    in_pixel_red   <= r;
    in_pixel_green <= g;
    in_pixel_blue  <= b;
    in_frame_start <= fs;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(r, g, b, fs);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_noise_pixel(input logic fs);
    send_pixel(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
               CHAN_W'($urandom_range(0, 255)), fs);
  endtask

  // let the last transaction finish, including one that yields no result
  task automatic drain_block();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    @(negedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CHAN_W-1:0] ro, input logic [CHAN_W-1:0] go,
                            input logic [CHAN_W-1:0] bo);
    logic [3:0] pad;
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    // upper data bits are don't-care for the offset registers
    pad = 4'($urandom_range(0, 15));
    write_reg(CFG_RED_OFFSET, {pad, ro});
    pad = 4'($urandom_range(0, 15));
    write_reg(CFG_GREEN_OFFSET, {pad, go});
    pad = 4'($urandom_range(0, 15));
    write_reg(CFG_BLUE_OFFSET, {pad, bo});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CHAN_W-1:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return CHAN_W'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    int unsigned first_random;
    int unsigned w, h, n, restart_at;
    bit          wrap;
    sb             = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FRAME_WIDTH;
    cfg_wdata      = '0;
    start          = 1'b0;
    in_pixel_red   = '0;
    in_pixel_green = '0;
    in_pixel_blue  = '0;
    in_frame_start = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default 640x480 geometry, then shrink to 1x1 with the counters past the limit
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    drain_block();
    set_size(12'd0, 12'd0);
    send_pixel(8'd128, 8'd64, 8'd32, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    drain_block();

    // oversized frame, then cut short mid line
    set_size(12'd4095, 12'd4095);
    send_noise_pixel(1'b1);
    repeat (3) send_noise_pixel(1'b0);
    drain_block();
    set_size(12'd2, 12'd2);
    repeat (3) send_noise_pixel(1'b0);
    drain_block();

    // smallest full frame: one pixel per segment in the band row, extreme channels
    set_config(12'd16, 12'd3, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 48; i++) begin
      if (i / 16 == 1)
        send_pixel((i % 2 == 0) ? 8'd255 : 8'd0, (i % 2 == 0) ? 8'd0 : 8'd255,
                   CHAN_W'((i % 16) * 17), 1'b0);
      else
        send_noise_pixel(i == 0);
    end
    drain_block();

    // two band rows summed, then height cut to one band row: means saturate
    set_config(12'd16, 12'd6, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 64; i++)
      send_pixel(CHAN_W'($urandom_range(128, 255)), CHAN_W'($urandom_range(128, 255)),
                 CHAN_W'($urandom_range(128, 255)), i == 0);
    drain_block();
    set_size(12'd16, 12'd3);
    repeat (16) send_noise_pixel(1'b0);

    first_random = pixels_sent;
    while (pixels_sent - first_random < RANDOM_ITEMS) begin
      drain_block();
      sender_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin w = 16; h = 3; end
            5, 6, 7: begin w = $urandom_range(17, 24); h = $urandom_range(3, 4); end
            default: begin w = 32; h = 3; end
          endcase
          set_config(CFG_W'(w), CFG_W'(h), pick_offset(), pick_offset(), pick_offset());
          n = w * h;
          wrap = ($urandom_range(0, 5) == 0);
          restart_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : 0;
          for (int i = 0; i < n; i++)
            send_noise_pixel((i == 0 && !wrap) || (restart_at != 0 && i == restart_at));
        end
        6, 7: begin
          set_config(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 2)),
                     pick_offset(), pick_offset(), pick_offset());
          n = $urandom_range(4, 12);
          repeat (n) send_noise_pixel($urandom_range(0, 3) == 0);
        end
        8: begin
          w = ($urandom_range(0, 3) == 0) ? $urandom_range(2048, 4095) : $urandom_range(16, 24);
          h = ($urandom_range(0, 3) == 0) ? $urandom_range(2048, 4095) : $urandom_range(4, 8);
          set_config(CFG_W'(w), CFG_W'(h), pick_offset(), pick_offset(), pick_offset());
          n = $urandom_range(8, 40);
          for (int i = 0; i < n; i++) send_noise_pixel(i == 0);
          drain_block();
          set_size(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(1, 4)));
          n = $urandom_range(1, 24);
          repeat (n) send_noise_pixel(1'b0);
        end
        default: begin
          set_config(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 6)),
                     pick_offset(), pick_offset(), pick_offset());
          repeat (10) send_noise_pixel(1'($urandom_range(0, 1)));
        end
      endcase
    end

    drain_block();
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
